/* hw/rtl/pdr_pkg.sv */
// Package for the planar dead-reckoning step core: widths, quadrant codes and the trig table.
package pdr_pkg;

  localparam int unsigned TABLE_BITS = 10;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned TURN_W     = 16;
  localparam int unsigned TRIG_W     = 16;
  localparam int unsigned QIDX_W     = TABLE_BITS - 2;
  localparam int unsigned QTAB_SIZE  = 1 << QIDX_W;
  localparam int unsigned PROD_W     = DATA_W + TRIG_W;
  localparam int unsigned TERM_W     = PROD_W - (TRIG_W - 1);
  localparam int unsigned VSUM_W     = TERM_W + 2;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q15_MAX     = 64'd32767;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef logic [QTAB_SIZE-1:0][2*TRIG_W-1:0] trig_tab_t;

  function automatic logic [63:0] horner_next(input logic [63:0] p);
    return (p > Q30_ONE) ? 64'd0 : (Q30_ONE - p);
  endfunction

  function automatic logic [TRIG_W-1:0] to_q15(input logic [63:0] v);
    logic [63:0] rr;
    rr = (v + 64'd16384) >> 15;
    return (rr > Q15_MAX) ? Q15_MAX[TRIG_W-1:0] : rr[TRIG_W-1:0];
  endfunction

  // First-quadrant sine and cosine for one table entry, packed as {sine, cosine}.
  function automatic logic [2*TRIG_W-1:0] trig_entry(input int unsigned j);
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [TRIG_W-1:0] s;
    logic [TRIG_W-1:0] c;
    r  = 64'(j) << (ANGLE_W - TABLE_BITS);
    x  = (r * HALF_PI_Q30) >> 14;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = horner_next(((x2 * t) >> 30) / 64'd110);
    t  = horner_next(((x2 * t) >> 30) / 64'd72);
    t  = horner_next(((x2 * t) >> 30) / 64'd42);
    t  = horner_next(((x2 * t) >> 30) / 64'd20);
    t  = horner_next(((x2 * t) >> 30) / 64'd6);
    s  = to_q15((x * t) >> 30);
    t  = Q30_ONE;
    t  = horner_next(((x2 * t) >> 30) / 64'd132);
    t  = horner_next(((x2 * t) >> 30) / 64'd90);
    t  = horner_next(((x2 * t) >> 30) / 64'd56);
    t  = horner_next(((x2 * t) >> 30) / 64'd30);
    t  = horner_next(((x2 * t) >> 30) / 64'd12);
    t  = horner_next(((x2 * t) >> 30) / 64'd2);
    c  = to_q15(t);
    return {s, c};
  endfunction

  function automatic trig_tab_t build_trig_tab();
    trig_tab_t tab;
    for (int unsigned j = 0; j < QTAB_SIZE; j++) begin
      tab[j] = trig_entry(j);
    end
    return tab;
  endfunction

  localparam trig_tab_t TRIG_QTAB = build_trig_tab();

endpackage

/* hw/rtl/pose_dead_reckoning_step_core.sv */
// Top level of the planar dead-reckoning step core: pose state, update datapath and handshakes.
//
// Each item on the input channel (in_valid_i / in_ready_o) carries a body-frame
// forward and lateral acceleration and a turn acceleration. The core keeps the
// planar pose and returns the new pose as one item on the output channel
// (out_valid_o / out_ready_i) for every input item, in order.
// An accepted item is held in an input register; the update then runs from it
// and loads the pose registers, which drive the outputs directly, once the pose
// registers are empty or their result is being taken. A result is offered from
// the pose registers and held there until the receiver takes it.
// One item is accepted in every cycle while the receiver keeps up; the rate is
// set by the single update stage between the input register and the pose
// registers, which holds a quarter-wave trig table read and four 32 by 16
// multipliers.
// When the receiver stalls, the result waits in the pose registers and the
// input register still takes one more item; after that in_ready_o drops until
// the result is taken.
// Reset clears the pose, heading and turn rate to zero and empties both
// registers; the first result after reset starts from the zero pose.
module pose_dead_reckoning_step_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [pdr_pkg::DATA_W-1:0]   accel_forward_i,
  input  logic signed [pdr_pkg::DATA_W-1:0]   accel_lateral_i,
  input  logic signed [pdr_pkg::TURN_W-1:0]   turn_accel_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [pdr_pkg::DATA_W-1:0]   out_x_o,
  output logic signed [pdr_pkg::DATA_W-1:0]   out_y_o,
  output logic signed [pdr_pkg::DATA_W-1:0]   out_vx_o,
  output logic signed [pdr_pkg::DATA_W-1:0]   out_vy_o,
  output logic        [pdr_pkg::ANGLE_W-1:0]  out_heading_o,
  output logic signed [pdr_pkg::TURN_W-1:0]   out_turn_rate_o
);

  logic                                 in_valid_q;
  logic signed [pdr_pkg::DATA_W-1:0]    af_q;
  logic signed [pdr_pkg::DATA_W-1:0]    al_q;
  logic signed [pdr_pkg::TURN_W-1:0]    ta_q;

  logic                                 out_valid_q;
  logic signed [pdr_pkg::DATA_W-1:0]    pos_x_q, pos_x_d;
  logic signed [pdr_pkg::DATA_W-1:0]    pos_y_q, pos_y_d;
  logic signed [pdr_pkg::DATA_W-1:0]    vel_x_q, vel_x_d;
  logic signed [pdr_pkg::DATA_W-1:0]    vel_y_q, vel_y_d;
  logic        [pdr_pkg::ANGLE_W-1:0]   heading_q, heading_d;
  logic signed [pdr_pkg::TURN_W-1:0]    rate_q, rate_d;

  logic                                 update;
  logic                                 in_take;

  logic [pdr_pkg::TABLE_BITS-1:0]       tab_idx;
  logic [pdr_pkg::QIDX_W-1:0]           qidx;
  logic [2*pdr_pkg::TRIG_W-1:0]         qentry;
  logic signed [pdr_pkg::TRIG_W-1:0]    qsin, qcos;
  logic signed [pdr_pkg::TRIG_W-1:0]    sin_val, cos_val;

  logic signed [pdr_pkg::PROD_W-1:0]    p_fc, p_ls, p_fs, p_lc;
  logic signed [pdr_pkg::TERM_W-1:0]    t_fc, t_ls, t_fs, t_lc;
  logic signed [pdr_pkg::VSUM_W-1:0]    vx_sum, vy_sum, x_sum, y_sum;
  logic signed [pdr_pkg::TURN_W:0]      rate_sum;

  function automatic logic signed [pdr_pkg::DATA_W-1:0] sat_data(
    input logic signed [pdr_pkg::VSUM_W-1:0] v
  );
    logic [pdr_pkg::VSUM_W-pdr_pkg::DATA_W:0] top;
    top = v[pdr_pkg::VSUM_W-1:pdr_pkg::DATA_W-1];
    if ((top == '0) || (top == '1)) begin
      return v[pdr_pkg::DATA_W-1:0];
    end else if (v[pdr_pkg::VSUM_W-1]) begin
      return {1'b1, {(pdr_pkg::DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(pdr_pkg::DATA_W-1){1'b1}}};
    end
  endfunction

  assign update     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || update;
  assign in_take    = in_valid_i && in_ready_o;

  // Trig lookup on the top heading bits, folded from the first quadrant.
  assign tab_idx = heading_q[pdr_pkg::ANGLE_W-1 -: pdr_pkg::TABLE_BITS];
  assign qidx    = tab_idx[pdr_pkg::QIDX_W-1:0];
  assign qentry  = pdr_pkg::TRIG_QTAB[qidx];
  assign qsin    = qentry[2*pdr_pkg::TRIG_W-1:pdr_pkg::TRIG_W];
  assign qcos    = qentry[pdr_pkg::TRIG_W-1:0];

  always_comb begin
    case (pdr_pkg::quad_e'(tab_idx[pdr_pkg::TABLE_BITS-1 -: 2]))
      pdr_pkg::QUAD_0: begin
        sin_val = qsin;
        cos_val = qcos;
      end
      pdr_pkg::QUAD_1: begin
        sin_val = qcos;
        cos_val = -qsin;
      end
      pdr_pkg::QUAD_2: begin
        sin_val = -qsin;
        cos_val = -qcos;
      end
      pdr_pkg::QUAD_3: begin
        sin_val = -qcos;
        cos_val = qsin;
      end
      default: begin
        sin_val = qsin;
        cos_val = qcos;
      end
    endcase
  end

  assign p_fc = af_q * cos_val;
  assign p_ls = al_q * sin_val;
  assign p_fs = af_q * sin_val;
  assign p_lc = al_q * cos_val;

  // Dropping the low fraction bits is a floor shift by 15.
  assign t_fc = p_fc[pdr_pkg::PROD_W-1:pdr_pkg::TRIG_W-1];
  assign t_ls = p_ls[pdr_pkg::PROD_W-1:pdr_pkg::TRIG_W-1];
  assign t_fs = p_fs[pdr_pkg::PROD_W-1:pdr_pkg::TRIG_W-1];
  assign t_lc = p_lc[pdr_pkg::PROD_W-1:pdr_pkg::TRIG_W-1];

  assign vx_sum = pdr_pkg::VSUM_W'(vel_x_q) + pdr_pkg::VSUM_W'(t_fc) - pdr_pkg::VSUM_W'(t_ls);
  assign vy_sum = pdr_pkg::VSUM_W'(vel_y_q) + pdr_pkg::VSUM_W'(t_fs) + pdr_pkg::VSUM_W'(t_lc);
  assign x_sum  = pdr_pkg::VSUM_W'(pos_x_q) + pdr_pkg::VSUM_W'(vel_x_q);
  assign y_sum  = pdr_pkg::VSUM_W'(pos_y_q) + pdr_pkg::VSUM_W'(vel_y_q);

  assign rate_sum = (pdr_pkg::TURN_W+1)'(rate_q) + (pdr_pkg::TURN_W+1)'(ta_q);

  always_comb begin
    pos_x_d   = sat_data(x_sum);
    pos_y_d   = sat_data(y_sum);
    vel_x_d   = sat_data(vx_sum);
    vel_y_d   = sat_data(vy_sum);
    heading_d = heading_q + $unsigned(rate_q);
    if (rate_sum[pdr_pkg::TURN_W] == rate_sum[pdr_pkg::TURN_W-1]) begin
      rate_d = rate_sum[pdr_pkg::TURN_W-1:0];
    end else if (rate_sum[pdr_pkg::TURN_W]) begin
      rate_d = {1'b1, {(pdr_pkg::TURN_W-1){1'b0}}};
    end else begin
      rate_d = {1'b0, {(pdr_pkg::TURN_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      af_q <= accel_forward_i;
      al_q <= accel_lateral_i;
      ta_q <= turn_accel_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
      heading_q   <= '0;
      rate_q      <= '0;
    end else begin
      if (update) begin
        out_valid_q <= 1'b1;
        pos_x_q     <= pos_x_d;
        pos_y_q     <= pos_y_d;
        vel_x_q     <= vel_x_d;
        vel_y_q     <= vel_y_d;
        heading_q   <= heading_d;
        rate_q      <= rate_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_x_o         = pos_x_q;
  assign out_y_o         = pos_y_q;
  assign out_vx_o        = vel_x_q;
  assign out_vy_o        = vel_y_q;
  assign out_heading_o   = heading_q;
  assign out_turn_rate_o = rate_q;

  a_update_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    update |=> out_valid_o)
    else $error("An update did not present a result.");

  a_pending_item_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !update) |=> (in_valid_q && $stable(af_q) && $stable(al_q)
      && $stable(ta_q)))
    else $error("A waiting input item was lost or changed.");

  a_heading_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    update |=> (out_heading_o == $past(heading_q + $unsigned(rate_q))))
    else $error("Heading did not advance by the previous turn rate.");

  a_pose_frozen_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !update |=> ($stable(pos_x_q) && $stable(vel_y_q) && $stable(rate_q)))
    else $error("Pose changed without an update.");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the dead-reckoning step core, with its own pose predictor.
module tb_top;

  localparam int unsigned TABLE_BITS = pdr_pkg::TABLE_BITS;
  localparam int unsigned DATA_W = pdr_pkg::DATA_W;
  localparam int unsigned ANGLE_W = pdr_pkg::ANGLE_W;
  localparam int unsigned TURN_W = pdr_pkg::TURN_W;
  localparam int unsigned TRIG_ENTRIES = 1 << TABLE_BITS;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 10;
  localparam int REPORT_MAX = 10;
  localparam int RANDOM_ITEMS = 2000;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam logic signed [DATA_W-1:0] ACC_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] ACC_MIN = 32'sh8000_0000;
  localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7FFF;
  localparam logic signed [TURN_W-1:0] TURN_MIN = 16'sh8000;

  typedef struct {
    logic signed [DATA_W-1:0] fwd;
    logic signed [DATA_W-1:0] lat;
    logic signed [TURN_W-1:0] turn;
  } accel_item_t;

  typedef struct {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vy;
    logic [ANGLE_W-1:0]       heading;
    logic signed [TURN_W-1:0] rate;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DATA_W-1:0] accel_fwd = '0;
  logic signed [DATA_W-1:0] accel_lat = '0;
  logic signed [TURN_W-1:0] turn_acc = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_x;
  logic signed [DATA_W-1:0] out_y;
  logic signed [DATA_W-1:0] out_vx;
  logic signed [DATA_W-1:0] out_vy;
  logic [ANGLE_W-1:0]       out_heading;
  logic signed [TURN_W-1:0] out_rate;

  int trig_sin [TRIG_ENTRIES];
  int trig_cos [TRIG_ENTRIES];
  pose_t pose_now;
  accel_item_t pending_q[$];
  pose_t pose_q[$];
  accel_item_t next_item;
  accel_item_t taken_item;
  pose_t want;

  bit in_taken;
  bit out_taken;
  int in_gap;
  int in_calm;
  int out_hold;
  int out_calm;
  int cycle_count;
  int items_sent;
  int results_seen;
  int errors;
  int sat_pos_seen;
  int sat_vel_seen;
  int sat_rate_seen;

  pose_dead_reckoning_step_core u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .accel_forward_i (accel_fwd),
    .accel_lateral_i (accel_lat),
    .turn_accel_i    (turn_acc),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .out_x_o         (out_x),
    .out_y_o         (out_y),
    .out_vx_o        (out_vx),
    .out_vy_o        (out_vy),
    .out_heading_o   (out_heading),
    .out_turn_rate_o (out_rate)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Truncating Horner evaluation of the sine or cosine series in Q30.
  function automatic longint unsigned series_tail(longint unsigned x2, bit for_cos);
    longint unsigned divs [6];
    longint unsigned acc;
    longint unsigned part;
    int terms;
    if (for_cos) begin
      divs = '{132, 90, 56, 30, 12, 2};
      terms = 6;
    end else begin
      divs = '{110, 72, 42, 20, 6, 1};
      terms = 5;
    end
    acc = ONE_Q30;
    for (int k = 0; k < terms; k++) begin
      part = ((x2 * acc) >> 30) / divs[k];
      acc = (part > ONE_Q30) ? 64'd0 : ONE_Q30 - part;
    end
    return acc;
  endfunction

  function automatic int q15_round(longint unsigned v);
    longint unsigned r;
    r = (v + 64'd16384) >> 15;
    return (r > 64'd32767) ? 32767 : int'(r);
  endfunction

  function automatic void fill_trig();
    longint unsigned ang;
    longint unsigned rem;
    longint unsigned xr;
    longint unsigned x2;
    int s;
    int c;
    for (int unsigned i = 0; i < TRIG_ENTRIES; i++) begin
      ang = (64'(i) << (ANGLE_W - TABLE_BITS)) & 64'hFFFF;
      rem = ang & 64'h3FFF;
      xr = (rem * QUARTER_TURN_Q30) >> 14;
      x2 = (xr * xr) >> 30;
      s = q15_round((xr * series_tail(x2, 1'b0)) >> 30);
      c = q15_round(series_tail(x2, 1'b1));
      case (pdr_pkg::quad_e'(ang[15:14]))
        pdr_pkg::QUAD_0: begin
          trig_sin[i] = s;
          trig_cos[i] = c;
        end
        pdr_pkg::QUAD_1: begin
          trig_sin[i] = c;
          trig_cos[i] = -s;
        end
        pdr_pkg::QUAD_2: begin
          trig_sin[i] = -s;
          trig_cos[i] = -c;
        end
        default: begin
          trig_sin[i] = -c;
          trig_cos[i] = s;
        end
      endcase
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp32(longint v);
    if (v > SAT_HI) return DATA_W'(SAT_HI);
    if (v < SAT_LO) return DATA_W'(SAT_LO);
    return DATA_W'(v);
  endfunction

  function automatic pose_t advance_pose(accel_item_t a);
    pose_t nxt;
    int idx;
    longint sn;
    longint cs;
    longint f;
    longint l;
    longint rate_sum;
    idx = int'(pose_now.heading >> (ANGLE_W - TABLE_BITS));
    sn = trig_sin[idx];
    cs = trig_cos[idx];
    f = a.fwd;
    l = a.lat;
    nxt.x = clamp32(longint'(pose_now.x) + longint'(pose_now.vx));
    nxt.y = clamp32(longint'(pose_now.y) + longint'(pose_now.vy));
    nxt.vx = clamp32(longint'(pose_now.vx) + ((f * cs) >>> 15) - ((l * sn) >>> 15));
    nxt.vy = clamp32(longint'(pose_now.vy) + ((f * sn) >>> 15) + ((l * cs) >>> 15));
    nxt.heading = pose_now.heading + ANGLE_W'(pose_now.rate);
    rate_sum = longint'(pose_now.rate) + longint'(a.turn);
    if (rate_sum > 32767) nxt.rate = TURN_MAX;
    else if (rate_sum < -32768) nxt.rate = TURN_MIN;
    else nxt.rate = TURN_W'(rate_sum);
    pose_now = nxt;
    return nxt;
  endfunction

  function automatic logic signed [DATA_W-1:0] draw_accel();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return DATA_W'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    if (pick < 80) return DATA_W'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
    if (pick < 92) return DATA_W'($urandom());
    case ($urandom_range(0, 3))
      0: return ACC_MAX;
      1: return ACC_MIN;
      2: return -32'sd1;
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [TURN_W-1:0] draw_turn();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return TURN_W'(int'($urandom_range(0, 128)) - 64);
    if (pick < 88) return TURN_W'($urandom());
    return pick[0] ? TURN_MAX : TURN_MIN;
  endfunction

  // Mostly short gaps, some long ones, and now and then a calm stretch with none.
  function automatic int draw_gap(inout int calm);
    int unsigned pick;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      calm = $urandom_range(30, 150);
      return 0;
    end
    if (pick < 45) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_item(logic signed [DATA_W-1:0] f, logic signed [DATA_W-1:0] l,
                          logic signed [TURN_W-1:0] t);
    accel_item_t it;
    it.fwd = f;
    it.lat = l;
    it.turn = t;
    pending_q.push_back(it);
  endtask

  task automatic log_mismatch(string what);
    errors++;
    if (errors <= REPORT_MAX) $display("Mismatch at result %0d: %s", results_seen, what);
  endtask

  task automatic compare_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v)
      log_mismatch($sformatf("%s expected %0d, got %0d", name, exp_v, act_v));
  endtask

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (pending_q.size() > 0) begin
          next_item = pending_q.pop_front();
          accel_fwd <= next_item.fwd;
          accel_lat <= next_item.lat;
          turn_acc <= next_item.turn;
          in_valid <= 1'b1;
          in_gap = draw_gap(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_hold == 0 && (out_taken || $urandom_range(0, 7) == 0))
        out_hold = draw_gap(out_calm);
      if (out_hold > 0) begin
        out_ready <= 1'b0;
        out_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    in_taken = 1'b0;
    out_taken = 1'b0;
    if (rst_n) begin
      cycle_count++;
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        taken_item.fwd = accel_fwd;
        taken_item.lat = accel_lat;
        taken_item.turn = turn_acc;
        pose_q.push_back(advance_pose(taken_item));
        items_sent++;
      end
      if (out_valid && out_ready) begin
        out_taken = 1'b1;
        if (pose_q.size() == 0) begin
          log_mismatch("result arrived with nothing outstanding");
        end else begin
          want = pose_q.pop_front();
          compare_field("x", want.x, out_x);
          compare_field("y", want.y, out_y);
          compare_field("vx", want.vx, out_vx);
          compare_field("vy", want.vy, out_vy);
          compare_field("heading", want.heading, out_heading);
          compare_field("turn rate", want.rate, out_rate);
          if (want.x == ACC_MAX || want.x == ACC_MIN || want.y == ACC_MAX || want.y == ACC_MIN)
            sat_pos_seen++;
          if (want.vx == ACC_MAX || want.vx == ACC_MIN || want.vy == ACC_MAX
              || want.vy == ACC_MIN)
            sat_vel_seen++;
          if (want.rate == TURN_MAX || want.rate == TURN_MIN) sat_rate_seen++;
        end
        results_seen++;
      end
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Timed out after %0d cycles with %0d results outstanding.",
                 cycle_count, pose_q.size() + pending_q.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    fill_trig();
    pose_now = '{default: '0};

    // Zero item, then single extremes while the heading is still zero.
    add_item('0, '0, '0);
    add_item(ACC_MAX, '0, '0);
    add_item('0, ACC_MAX, '0);
    add_item(ACC_MIN, ACC_MIN, TURN_MAX);
    // Turn rate runs into its positive limit and the heading wraps.
    add_item(32'sh5555_5555, 32'shAAAA_AAAA, TURN_MAX);
    add_item(-32'sd1, 32'sh0001_0000, TURN_MAX);
    add_item('0, '0, TURN_MAX);
    add_item('0, '0, TURN_MAX);
    // Turn rate runs into its negative limit.
    add_item(32'sh0000_8000, -32'sd1, TURN_MIN);
    add_item('0, '0, TURN_MIN);
    add_item('0, '0, TURN_MIN);
    add_item('0, '0, TURN_MIN);
    add_item('0, '0, -16'sd1);
    // Velocity and then position saturate high, then low.
    for (int i = 0; i < 4; i++) add_item(ACC_MAX, ACC_MAX, 16'sd1);
    for (int i = 0; i < 8; i++) add_item(ACC_MIN, ACC_MIN, -16'sd1);

    for (int i = 0; i < RANDOM_ITEMS; i++) add_item(draw_accel(), draw_accel(), draw_turn());

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid || pose_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items and checked %0d results in %0d cycles, %0d mismatches.",
             items_sent, results_seen, cycle_count, errors);
    $display("Results with saturated position %0d, velocity %0d, turn rate %0d.",
             sat_pos_seen, sat_vel_seen, sat_rate_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/pdr_pkg.sv
hw/rtl/pose_dead_reckoning_step_core.sv
verif/tb_top.sv
